### hdl/assert_macros.svh
// Assertion helpers for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Same on the block's default clock and reset names.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

### hdl/sbsn_pkg.sv
package sbsn_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_COMPUTE = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_STATS  = 2'd1,
    KIND_NORM   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_STAT,
    S_NORM_RD,
    S_NORM_OUT
  } state_t;

  typedef struct packed {
    logic    load_status;
    status_t status;
    logic    mem_wr;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    rd_en;
    logic    acc_en;
    logic    idx_clr;
    logic    idx_inc;
    logic    div_load;
    logic    div_step;
    logic    load_stat;
    logic    load_norm;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### hdl/sbsn_ctrl.sv
module sbsn_ctrl
  import sbsn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   take;

  assign take = in_valid && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && in_req_type == REQ_COMPUTE && !sts.count_zero) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_nxt = S_SCAN_ACC;
      S_SCAN_ACC: state_nxt = sts.idx_last ? S_DIV_LOAD : S_SCAN_RD;
      S_DIV_LOAD: state_nxt = S_DIV_RUN;
      S_DIV_RUN: begin
        if (sts.div_done) begin
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          state_nxt = S_NORM_RD;
        end
      end
      S_NORM_RD: state_nxt = S_NORM_OUT;
      S_NORM_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.idx_last ? S_IDLE : S_NORM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (take) begin
          unique case (in_req_type)
            REQ_ADD: begin
              cmd.load_status = 1'b1;
              if (sts.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.status  = ST_ACCEPTED;
                cmd.mem_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
              end
            end
            REQ_COMPUTE: begin
              if (sts.count_zero) begin
                cmd.load_status = 1'b1;
                cmd.status      = ST_EMPTY;
              end else begin
                cmd.idx_clr = 1'b1;
              end
            end
            REQ_CLEAR: begin
              cmd.load_status = 1'b1;
              cmd.status      = ST_CLEARED;
              cmd.cnt_clr     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: cmd.rd_en = 1'b1;
      S_SCAN_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DIV_LOAD: cmd.div_load = 1'b1;
      S_DIV_RUN:  cmd.div_step = !sts.div_done;
      S_STAT:     cmd.load_stat = sts.out_free;
      S_NORM_RD:  cmd.rd_en = 1'b1;
      S_NORM_OUT: begin
        if (sts.out_free) begin
          cmd.load_norm = 1'b1;
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/sbsn_dp.sv
module sbsn_dp
  import sbsn_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] in_sample,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_item_kind,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_max_value,
  output logic signed [15:0] out_min_value,
  output logic signed [23:0] out_mean_q8,
  output logic signed [16:0] out_norm_value,
  output logic               out_last
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW  = 16 + CW;
  localparam int DW  = SW + 8;
  localparam int SCW = $clog2(DW + 1);

  logic signed [15:0] mem [CAPACITY];
  logic signed [15:0] rd_data_r;

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  idx_r;
  logic signed [15:0] max_r;
  logic signed [15:0] min_r;
  logic signed [SW-1:0] sum_r;
  logic first;

  logic [DW-1:0]  dq_r;
  logic [CW:0]    rem_r;
  logic [SCW-1:0] step_r;
  logic [CW:0]    rem_sh;
  logic           rem_ge;
  logic [SW-1:0]  sum_mag;
  logic           sum_neg;
  logic [DW:0]    rnd;
  logic [16:0]    off_mag;
  logic signed [16:0] off_r;
  logic [23:0]    mean_mag;
  logic signed [23:0] mean_val;
  logic signed [17:0] norm_diff;

  logic out_valid_r;

  assign sts.count_zero = (count_r == '0);
  assign sts.full       = (count_r == CW'(CAPACITY));
  assign sts.idx_last   = (idx_r == count_r - CW'(1));
  assign sts.div_done   = (step_r == SCW'(DW));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[count_r[AW-1:0]] <= in_sample;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_clr) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  assign first = (idx_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      if (first) begin
        max_r <= rd_data_r;
        min_r <= rd_data_r;
        sum_r <= SW'(rd_data_r);
      end else begin
        if (rd_data_r > max_r) begin
          max_r <= rd_data_r;
        end
        if (rd_data_r < min_r) begin
          min_r <= rd_data_r;
        end
        sum_r <= sum_r + SW'(rd_data_r);
      end
    end
  end

  assign sum_neg = sum_r[SW-1];
  assign sum_mag = sum_neg ? (~sum_r + SW'(1)) : sum_r;

  assign rem_sh = {rem_r[CW-1:0], dq_r[DW-1]};
  assign rem_ge = (rem_sh >= {1'b0, count_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.div_load) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + SCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq_r  <= {sum_mag, 8'd0};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[DW-2:0], rem_ge};
      rem_r <= rem_ge ? (rem_sh - {1'b0, count_r}) : rem_sh;
    end
  end

  assign mean_mag  = dq_r[23:0];
  assign mean_val  = sum_neg ? (~mean_mag + 24'd1) : mean_mag;
  assign rnd       = {1'b0, dq_r} + (DW + 1)'(128);
  assign off_mag   = rnd[24:8];
  assign norm_diff = 18'(rd_data_r) - 18'(off_r);

  always_ff @(posedge clk) begin
    if (cmd.load_stat) begin
      off_r <= sum_neg ? (~off_mag + 17'd1) : off_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_status || cmd.load_stat || cmd.load_norm) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_status) begin
      out_item_kind  <= KIND_STATUS;
      out_status     <= cmd.status;
      out_max_value  <= '0;
      out_min_value  <= '0;
      out_mean_q8    <= '0;
      out_norm_value <= '0;
      out_last       <= 1'b1;
    end else if (cmd.load_stat) begin
      out_item_kind  <= KIND_STATS;
      out_status     <= ST_ACCEPTED;
      out_max_value  <= max_r;
      out_min_value  <= min_r;
      out_mean_q8    <= mean_val;
      out_norm_value <= '0;
      out_last       <= 1'b0;
    end else if (cmd.load_norm) begin
      out_item_kind  <= KIND_NORM;
      out_status     <= ST_ACCEPTED;
      out_max_value  <= '0;
      out_min_value  <= '0;
      out_mean_q8    <= '0;
      out_norm_value <= norm_diff[16:0];
      out_last       <= sts.idx_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/sample_buffer_stats_normalizer_top.sv
// Add, clear and compute on empty: result word loaded at the accepting edge, visible next
// cycle; one word taken per cycle while the output drains.
// Compute on N samples: a read and accumulate step per sample, a divider load, a bit-serial divide
// over D = 24 + clog2(CAPACITY+1) quotient bits (29 at 16), the statistics word, then a read and
// output step per normalized word, each held while the output stalls; next request once idle.
// Reset (synchronous, active low) clears the sample count and output valid; store is not cleared.
module sample_buffer_stats_normalizer_top
  import sbsn_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_item_kind,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_max_value,
  output logic signed [15:0] out_min_value,
  output logic signed [23:0] out_mean_q8,
  output logic signed [16:0] out_norm_value,
  output logic               out_last
);

  cmd_t cmd;
  sts_t sts;

  sbsn_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  sbsn_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_sample),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item_kind  (out_item_kind),
    .out_status     (out_status),
    .out_max_value  (out_max_value),
    .out_min_value  (out_min_value),
    .out_mean_q8    (out_mean_q8),
    .out_norm_value (out_norm_value),
    .out_last       (out_last)
  );

endmodule

### hdl/sbsn_checker.sv
`include "assert_macros.svh"

module sbsn_sva
  import sbsn_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_req_type,
  input logic signed [15:0] in_sample,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_item_kind,
  input logic [1:0]         out_status,
  input logic signed [15:0] out_max_value,
  input logic signed [15:0] out_min_value,
  input logic signed [23:0] out_mean_q8,
  input logic signed [16:0] out_norm_value,
  input logic               out_last
);

  `ASSERT_STD(a_out_hold, out_valid && !out_ready |=> out_valid, "out_valid dropped while stalled")
  `ASSERT_STD(a_out_stable,
              out_valid && !out_ready |=> $stable(out_item_kind) && $stable(out_last) &&
              $stable(out_norm_value) && $stable(out_mean_q8),
              "output word changed while stalled")
  `ASSERT_STD(a_status_last, out_valid && out_item_kind == KIND_STATUS |-> out_last,
              "status word without last")
  `ASSERT_STD(a_stats_order,
              out_valid && out_item_kind == KIND_STATS |-> !out_last &&
              out_min_value <= out_max_value && out_min_value <= 16'(out_mean_q8 >>> 8),
              "bad statistics word")
  `ASSERT_STD(a_ready_slot, in_ready |-> !out_valid || out_ready,
              "input taken with output slot busy")

endmodule

bind sample_buffer_stats_normalizer_top sbsn_sva u_sbsn_sva (.*);
